FILE: rtl/core/cmi_pkg.sv
// Shared types and constants for the column mean imputer.
`default_nettype none

package cmi_pkg;

  localparam int MAX_COLS_DEF   = 16;
  localparam int COUNT_BITS_DEF = 24;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_ACCUM  = 2'd1;
  localparam logic [1:0] KIND_IMPUTE = 2'd2;

  localparam logic REG_NUM_COLUMNS = 1'b0;
  localparam logic REG_ID_BASE     = 1'b1;

  localparam logic [4:0]  NUM_COLUMNS_RESET = 5'd1;
  localparam logic [16:0] WEIGHT_ONE        = 17'h10000;
  localparam logic [31:0] COUNTER_RESET     = 32'd1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         column;
    logic signed [31:0] cell_value;
    logic               present;
    logic               row_end;
    logic [31:0]        row_label;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               filled;
    logic               row_done;
    logic [16:0]        row_weight;
    logic [31:0]        new_label;
    logic [31:0]        source_label;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/column_mean_imputer_unit.sv
// Column mean imputer: per-column sums and counts, mean imputation, row weights.
//
// Usage: requests enter on req_valid/req_data and are taken when req_stall is low.
// A clear request empties all columns (their sums and counts read as zero). An
// accumulate request does a memory read, then a write back. An impute request reads
// the column, runs the mean division for a missing cell with a non-empty column,
// forms the row weight, with a division on a row end with some but not all cells
// missing, and then registers the response.
// One restoring divider, one bit a cycle, serves both the mean and the weight.
// req_stall is high while a request is in work.
// Each impute request yields one response on rsp_valid/rsp_data, held in an
// output register; a new request is taken while a response waits. If the
// response is still stalled when the next one finishes, the block waits.
// Configuration is written over the APB port while the block is idle:
// num_columns at 0x0, id_base at 0x4.
// Reset (rst, synchronous) empties all columns, clears the missing tally,
// sets the incomplete-row counter to 1, num_columns to 1 and id_base to 0.
`default_nettype none

module column_mean_imputer_unit #(
  parameter int MAX_COLS   = cmi_pkg::MAX_COLS_DEF,
  parameter int COUNT_BITS = cmi_pkg::COUNT_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_stall,
  input  wire cmi_pkg::req_t req_data,
  output logic              rsp_valid,
  input  wire logic         rsp_stall,
  output cmi_pkg::rsp_t     rsp_data,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SUM_W = 32 + COUNT_BITS;
  localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_RD,
    ST_DIV_MEAN,
    ST_ROW,
    ST_DIV_WT,
    ST_DONE
  } state_t;

  state_t                  state;
  cmi_pkg::req_t           cur;
  logic [4:0]              num_columns;
  logic [31:0]             id_base;
  logic [4:0]              row_missing;
  logic [31:0]             incomplete_counter;
  logic [MAX_COLS-1:0]     col_valid;

  logic signed [SUM_W-1:0] sum_mem [MAX_COLS];
  logic [COUNT_BITS-1:0]   count_mem [MAX_COLS];
  logic signed [SUM_W-1:0] rd_sum;
  logic [COUNT_BITS-1:0]   rd_count;
  logic                    rd_valid;

  logic [COUNT_BITS-1:0]   rem;
  logic [COUNT_BITS-1:0]   divisor;
  logic [31:0]             dvd;
  logic [31:0]             quo;
  logic [4:0]              step;
  logic                    neg;
  logic signed [31:0]      res_value;
  logic [16:0]             weight;

  logic                    req_take;
  logic                    cfg_write;
  logic [3:0]              mem_col;
  logic [IDX_W-1:0]        mem_idx;
  logic                    in_range;
  logic                    mem_we;
  logic signed [SUM_W-1:0] sum_eff;
  logic [COUNT_BITS-1:0]   count_eff;
  logic [SUM_W-1:0]        sum_mag;
  logic [4:0]              missing_next;
  logic [4:0]              n_eff;
  logic                    rsp_free;

  logic [COUNT_BITS:0]     shifted;
  logic [COUNT_BITS:0]     diff;
  logic                    ge;
  logic [COUNT_BITS-1:0]   rem_next;
  logic [31:0]             quo_next;
  logic [31:0]             dvd_next;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == cmi_pkg::REG_ID_BASE) ? id_base : {27'd0, num_columns};

  assign mem_col  = (state == ST_IDLE) ? req_data.column : cur.column;
  assign mem_idx  = IDX_W'(mem_col);
  assign in_range = (32'(mem_col) < MAX_COLS);

  assign sum_eff   = rd_valid ? rd_sum : '0;
  assign count_eff = rd_valid ? rd_count : '0;
  assign sum_mag   = rd_sum[SUM_W-1] ? SUM_W'(-rd_sum) : SUM_W'(rd_sum);
  assign mem_we    = (state == ST_ACC) && cur.present && in_range && (count_eff != '1);

  assign missing_next = (!cur.present && (row_missing != 5'd31)) ? row_missing + 5'd1
                                                                 : row_missing;
  assign n_eff        = (num_columns == 5'd0) ? 5'd1 : num_columns;
  assign rsp_free     = !rsp_valid || !rsp_stall;

  assign shifted  = {rem, dvd[31]};
  assign ge       = (shifted >= {1'b0, divisor});
  assign diff     = shifted - {1'b0, divisor};
  assign rem_next = ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
  assign quo_next = {quo[30:0], ge};
  assign dvd_next = {dvd[30:0], 1'b0};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[mem_idx]   <= sum_eff + {{COUNT_BITS{cur.cell_value[31]}}, cur.cell_value};
      count_mem[mem_idx] <= count_eff + 1'b1;
    end
    rd_sum   <= sum_mem[mem_idx];
    rd_count <= count_mem[mem_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      num_columns        <= cmi_pkg::NUM_COLUMNS_RESET;
      id_base            <= '0;
      row_missing        <= '0;
      incomplete_counter <= cmi_pkg::COUNTER_RESET;
      col_valid          <= '0;
      rd_valid           <= 1'b0;
      rsp_valid          <= 1'b0;
    end else begin
      rd_valid <= col_valid[mem_idx] && in_range;
      if (cfg_write) begin
        unique case (paddr[2])
          cmi_pkg::REG_NUM_COLUMNS: num_columns <= pwdata[4:0];
          cmi_pkg::REG_ID_BASE:     id_base     <= pwdata;
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_take) begin
            cur <= req_data;
            unique case (req_data.kind)
              cmi_pkg::KIND_CLEAR:  col_valid <= '0;
              cmi_pkg::KIND_ACCUM:  state <= ST_ACC;
              cmi_pkg::KIND_IMPUTE: state <= ST_RD;
              default: ;
            endcase
          end
        end
        ST_ACC: begin
          if (mem_we) begin
            col_valid[mem_idx] <= 1'b1;
          end
          state <= ST_IDLE;
        end
        ST_RD: begin
          row_missing <= missing_next;
          if (cur.present) begin
            res_value <= cur.cell_value;
            state     <= ST_ROW;
          end else if (count_eff == '0) begin
            res_value <= '0;
            state     <= ST_ROW;
          end else begin
            neg     <= rd_sum[SUM_W-1];
            rem     <= sum_mag[SUM_W-1:32];
            dvd     <= sum_mag[31:0];
            divisor <= rd_count;
            step    <= 5'd31;
            state   <= ST_DIV_MEAN;
          end
        end
        ST_DIV_MEAN: begin
          rem  <= rem_next;
          quo  <= quo_next;
          dvd  <= dvd_next;
          step <= step - 5'd1;
          if (step == 5'd0) begin
            res_value <= neg ? -quo_next : quo_next;
            state     <= ST_ROW;
          end
        end
        ST_ROW: begin
          if (!cur.row_end || (row_missing >= n_eff)) begin
            weight <= '0;
            state  <= ST_DONE;
          end else if (row_missing == 5'd0) begin
            weight <= cmi_pkg::WEIGHT_ONE;
            state  <= ST_DONE;
          end else begin
            rem     <= COUNT_BITS'(n_eff - row_missing);
            dvd     <= '0;
            divisor <= COUNT_BITS'(n_eff);
            step    <= 5'd15;
            state   <= ST_DIV_WT;
          end
        end
        ST_DIV_WT: begin
          rem  <= rem_next;
          quo  <= quo_next;
          dvd  <= dvd_next;
          step <= step - 5'd1;
          if (step == 5'd0) begin
            weight <= {1'b0, quo_next[15:0]};
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (rsp_free) begin
            rsp_valid              <= 1'b1;
            rsp_data.out_value     <= res_value;
            rsp_data.filled        <= !cur.present;
            rsp_data.row_done      <= cur.row_end;
            rsp_data.row_weight    <= weight;
            if (cur.row_end && (row_missing != 5'd0)) begin
              rsp_data.new_label    <= id_base + incomplete_counter;
              rsp_data.source_label <= cur.row_label;
              incomplete_counter    <= incomplete_counter + 32'd1;
            end else begin
              rsp_data.new_label    <= cur.row_end ? cur.row_label : '0;
              rsp_data.source_label <= '0;
            end
            if (cur.row_end) begin
              row_missing <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
